>>> rtl/core/sil_pkg.sv
// Shared types and codes for the sorted insert list block.
// No dependencies; imported by every module of the block.
`default_nettype none

package sil_pkg;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_DUMP   = 1'b1
   } sil_op_type;

   typedef enum logic [1:0] {
      RSP_INSERTED   = 2'd0,
      RSP_FULL       = 2'd1,
      RSP_DUMP_ENTRY = 2'd2,
      RSP_DUMP_EMPTY = 2'd3
   } sil_status_type;

   typedef enum logic [1:0] {
      S_RUN  = 2'b01,
      S_DUMP = 2'b10
   } sil_state_type;

   // Head of the command queue as seen by the table.
   typedef struct packed {
      logic       valid;
      sil_op_type op;
   } sil_head_type;

endpackage

`default_nettype wire

>>> rtl/core/sil_queue.sv
// Front end: two-entry command queue that takes request transactions.
// Depends on sil_pkg.
`default_nettype none

module sil_queue
   import sil_pkg::*;
#(
   parameter int NAME_BITS = 64
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire                   req_operation,
   input  wire signed [31:0]     req_key,
   input  wire [NAME_BITS-1:0]   req_name_tag,
   output sil_head_type          head,
   output logic signed [31:0]    head_key,
   output logic [NAME_BITS-1:0]  head_name,
   input  wire                   pop
);

   localparam logic [1:0] SLOTS = 2'd2;

   sil_op_type               op_ff   [2];
   logic signed [31:0]       key_ff  [2];
   logic [NAME_BITS-1:0]     name_ff [2];
   logic                     wr_ptr_ff, wr_ptr_in;
   logic                     rd_ptr_ff, rd_ptr_in;
   logic [1:0]               fill_ff, fill_in;
   logic                     push;
   logic                     do_pop;

   assign req_ready = (fill_ff != SLOTS);
   assign push      = req_valid && req_ready;
   assign do_pop    = pop && (fill_ff != 2'd0);

   assign head.valid = (fill_ff != 2'd0);
   assign head.op    = op_ff[rd_ptr_ff];
   assign head_key   = key_ff[rd_ptr_ff];
   assign head_name  = name_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         op_ff[wr_ptr_ff]   <= sil_op_type'(req_operation);
         key_ff[wr_ptr_ff]  <= req_key;
         name_ff[wr_ptr_ff] <= req_name_tag;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/sil_table.sv
// Back end: sorted cell chain, dump sequencer and response register.
// Depends on sil_pkg; fed by sil_queue.
`default_nettype none

module sil_table
   import sil_pkg::*;
#(
   parameter int DEPTH     = 16,
   parameter int NAME_BITS = 64
) (
   input  wire                    clock,
   input  wire                    reset,
   input  sil_head_type           head,
   input  wire signed [31:0]      head_key,
   input  wire [NAME_BITS-1:0]    head_name,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output logic [1:0]             rsp_status,
   output logic signed [31:0]     rsp_out_key,
   output logic [NAME_BITS-1:0]   rsp_out_name_tag,
   output logic                   rsp_last
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic signed [31:0]    keys_ff  [DEPTH];
   logic signed [31:0]    keys_in  [DEPTH];
   logic [NAME_BITS-1:0]  names_ff [DEPTH];
   logic [NAME_BITS-1:0]  names_in [DEPTH];
   logic [DEPTH-1:0]      after;
   logic                  lt0;

   logic [CNT_W-1:0]      count_ff, count_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   sil_state_type         state_ff, state_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   sil_status_type        rsp_status_ff, rsp_status_in;
   logic signed [31:0]    rsp_key_ff, rsp_key_in;
   logic [NAME_BITS-1:0]  rsp_name_ff, rsp_name_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  can_load;
   logic                  ins_go;
   logic                  rd_last;

   // Cell chain: each cell decides locally whether it takes the new record,
   // takes its lower neighbor's record, or keeps its own.
   always_comb begin
      lt0 = (count_ff == '0) || (head_key < keys_ff[0]);
      for (int i = 0; i < DEPTH; i++) begin
         if (i == 0) begin
            after[i]    = lt0;
            keys_in[i]  = lt0 ? head_key : keys_ff[i];
            names_in[i] = lt0 ? head_name : names_ff[i];
         end else begin
            after[i] = lt0 || (CNT_W'(i) >= count_ff) || !(keys_ff[i] < head_key);
            if (after[i] && after[i-1]) begin
               keys_in[i]  = keys_ff[i-1];
               names_in[i] = names_ff[i-1];
            end else if (after[i]) begin
               keys_in[i]  = head_key;
               names_in[i] = head_name;
            end else begin
               keys_in[i]  = keys_ff[i];
               names_in[i] = names_ff[i];
            end
         end
      end
   end

   assign can_load = !rsp_valid_ff || rsp_ready;
   assign rd_last  = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);

   always_comb begin
      count_in      = count_ff;
      idx_in        = idx_ff;
      state_in      = state_ff;
      pop           = 1'b0;
      ins_go        = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_name_in   = rsp_name_ff;
      rsp_last_in   = rsp_last_ff;
      unique case (state_ff)
         S_RUN: begin
            if (head.valid && can_load) begin
               rsp_valid_in = 1'b1;
               rsp_key_in   = '0;
               rsp_name_in  = '0;
               rsp_last_in  = 1'b1;
               pop          = 1'b1;
               if (head.op == OP_INSERT) begin
                  if (count_ff == FULL_CNT) begin
                     rsp_status_in = RSP_FULL;
                  end else begin
                     rsp_status_in = RSP_INSERTED;
                     ins_go        = 1'b1;
                     count_in      = count_ff + CNT_W'(1);
                  end
               end else if (count_ff == '0) begin
                  rsp_status_in = RSP_DUMP_EMPTY;
               end else begin
                  rsp_status_in = RSP_DUMP_ENTRY;
                  rsp_key_in    = keys_ff[idx_ff];
                  rsp_name_in   = names_ff[idx_ff];
                  rsp_last_in   = rd_last;
                  if (!rd_last) begin
                     pop      = 1'b0;
                     idx_in   = idx_ff + IDX_W'(1);
                     state_in = S_DUMP;
                  end
               end
            end
         end
         S_DUMP: begin
            if (can_load) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = RSP_DUMP_ENTRY;
               rsp_key_in    = keys_ff[idx_ff];
               rsp_name_in   = names_ff[idx_ff];
               rsp_last_in   = rd_last;
               if (rd_last) begin
                  pop      = 1'b1;
                  idx_in   = '0;
                  state_in = S_RUN;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = S_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         idx_ff       <= '0;
         state_ff     <= S_RUN;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_name_ff   <= rsp_name_in;
      rsp_last_ff   <= rsp_last_in;
      if (ins_go) begin
         keys_ff  <= keys_in;
         names_ff <= names_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_key      = rsp_key_ff;
   assign rsp_out_name_tag = rsp_name_ff;
   assign rsp_last         = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("entry count above depth");

   a_dump_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DUMP) |-> (CNT_W'(idx_ff) < count_ff))
      else $error("dump index beyond stored entries");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      ins_go |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("insert did not grow the table");

   a_dump_freezes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DUMP) |-> !ins_go)
      else $error("table written during dump");

endmodule

`default_nettype wire

>>> rtl/core/sorted_insert_list.sv
// Sorted insert list: a bounded table of records kept in ascending key order.
// Request transactions carry an operation (insert or dump), a signed key and
// a name tag; response transactions carry status, key, name tag and a last
// flag. Both channels use valid/ready.
// An insert answers with one response (inserted or full). A dump answers
// with one response per stored record, in key order, last set on the final
// one; an empty table answers with a single empty response.
// Requests enter a two-entry queue; the table pops the head, shifts its cell
// chain and loads the response register. Inserts sustain one per cycle while
// the receiver is ready; a dump holds the table until its final record is
// loaded, set by the single response register emitting one record a cycle
// while the receiver is ready, and later requests wait in the queue.
// When the receiver stalls, the response register holds its transaction and
// the table waits; the queue still takes up to two requests.
// Reset empties the table, the queue and the response register; record
// contents are not cleared, and no clearing pass is needed.
// Depends on sil_pkg, sil_queue and sil_table.
`default_nettype none

module sorted_insert_list
   import sil_pkg::*;
#(
   parameter int DEPTH     = 16,
   parameter int NAME_BITS = 64
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  wire                    req_operation,
   input  wire signed [31:0]      req_key,
   input  wire [NAME_BITS-1:0]    req_name_tag,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output logic [1:0]             rsp_status,
   output logic signed [31:0]     rsp_out_key,
   output logic [NAME_BITS-1:0]   rsp_out_name_tag,
   output logic                   rsp_last
);

   sil_head_type            head;
   logic signed [31:0]      head_key;
   logic [NAME_BITS-1:0]    head_name;
   logic                    pop;

   sil_queue #(
      .NAME_BITS (NAME_BITS)
   ) u_queue (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_key       (req_key),
      .req_name_tag  (req_name_tag),
      .head          (head),
      .head_key      (head_key),
      .head_name     (head_name),
      .pop           (pop)
   );

   sil_table #(
      .DEPTH     (DEPTH),
      .NAME_BITS (NAME_BITS)
   ) u_table (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .head_key         (head_key),
      .head_name        (head_name),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_out_key      (rsp_out_key),
      .rsp_out_name_tag (rsp_out_name_tag),
      .rsp_last         (rsp_last)
   );

endmodule

`default_nettype wire

>>> tb/sil_checker.sv
// Response checker for the sorted insert list: predicts the table from accepted
// requests and compares every response transaction in order.
// Depends on sil_pkg.
module sil_checker
   import sil_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   input  wire               req_ready,
   input  wire               req_operation,
   input  wire signed [31:0] req_key,
   input  wire [63:0]        req_name_tag,
   input  wire               rsp_valid,
   input  wire               rsp_ready,
   input  wire [1:0]         rsp_status,
   input  wire signed [31:0] rsp_out_key,
   input  wire [63:0]        rsp_out_name_tag,
   input  wire               rsp_last,
   output int                failures,
   output int                pending
);

   typedef struct packed {
      sil_status_type     status;
      logic signed [31:0] key;
      logic [63:0]        tag;
      logic               last;
   } sil_result_type;

   sil_result_type     result_q[$];
   logic signed [31:0] model_keys[DEPTH];
   logic [63:0]        model_tags[DEPTH];
   int                 model_count;

   initial begin
      failures    = 0;
      pending     = 0;
      model_count = 0;
   end

   function automatic sil_result_type make_result(sil_status_type status,
                                                  logic signed [31:0] key,
                                                  logic [63:0] tag, logic last);
      sil_result_type r;
      r.status = status;
      r.key    = key;
      r.tag    = tag;
      r.last   = last;
      return r;
   endfunction

   task automatic apply_request(input sil_op_type op, input logic signed [31:0] key,
                                input logic [63:0] tag);
      int pos;
      if (op == OP_DUMP) begin
         if (model_count == 0)
            result_q.push_back(make_result(RSP_DUMP_EMPTY, '0, '0, 1'b1));
         for (int i = 0; i < model_count; i++)
            result_q.push_back(make_result(RSP_DUMP_ENTRY, model_keys[i], model_tags[i],
                                           i == model_count - 1));
      end else if (model_count >= DEPTH) begin
         result_q.push_back(make_result(RSP_FULL, '0, '0, 1'b1));
      end else begin
         // equal key to entry 0 lands after it, but before equal later entries
         if (model_count == 0 || key < model_keys[0]) begin
            pos = 0;
         end else begin
            pos = 1;
            while (pos < model_count && model_keys[pos] < key)
               pos++;
         end
         for (int i = model_count; i > pos; i--) begin
            model_keys[i] = model_keys[i-1];
            model_tags[i] = model_tags[i-1];
         end
         model_keys[pos] = key;
         model_tags[pos] = tag;
         model_count++;
         result_q.push_back(make_result(RSP_INSERTED, '0, '0, 1'b1));
      end
   endtask

   task automatic compare_field(input string field, input logic [63:0] exp_value,
                                input logic [63:0] act_value);
      if (exp_value !== act_value) begin
         $error("%s mismatch: expected %0h, actual %0h", field, exp_value, act_value);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      sil_result_type exp_result;
      if (reset) begin
         model_count = 0;
         result_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (result_q.size() == 0) begin
               $error("response transaction with no expected result");
               failures++;
            end else begin
               exp_result = result_q.pop_front();
               compare_field("status", 64'(exp_result.status), 64'(rsp_status));
               compare_field("out_key", 64'(unsigned'(exp_result.key)),
                             64'(unsigned'(rsp_out_key)));
               compare_field("out_name_tag", exp_result.tag, rsp_out_name_tag);
               compare_field("last", 64'(exp_result.last), 64'(rsp_last));
            end
         end
         if (req_valid && req_ready)
            apply_request(sil_op_type'(req_operation), req_key, req_name_tag);
      end
      pending = result_q.size();
   end

endmodule

>>> tb/tb.sv
// Testbench top for sorted_insert_list: drives request transactions with random
// gaps and response back-pressure; sil_checker predicts and compares.
// Depends on sil_pkg, sorted_insert_list and sil_checker.
module tb
   import sil_pkg::*;
();

   localparam int DEPTH       = 16;
   localparam int CYCLE_LIMIT = 200000;

   logic               clock         = 1'b0;
   logic               reset         = 1'b1;
   logic               req_valid     = 1'b0;
   logic               req_operation = 1'b0;
   logic signed [31:0] req_key       = '0;
   logic [63:0]        req_name_tag  = '0;
   logic               rsp_ready     = 1'b0;
   logic               req_ready;
   logic               rsp_valid;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_out_key;
   logic [63:0]        rsp_out_name_tag;
   logic               rsp_last;
   logic               quiet         = 1'b0;
   int                 failures;
   int                 pending;
   int                 cycle_count   = 0;

   always #2 clock = ~clock;

   sorted_insert_list #(.DEPTH(DEPTH), .NAME_BITS(64)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_operation(req_operation),
      .req_key(req_key), .req_name_tag(req_name_tag),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_out_key(rsp_out_key), .rsp_out_name_tag(rsp_out_name_tag),
      .rsp_last(rsp_last)
   );

   sil_checker #(.DEPTH(DEPTH)) u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_operation(req_operation),
      .req_key(req_key), .req_name_tag(req_name_tag),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_out_key(rsp_out_key), .rsp_out_name_tag(rsp_out_name_tag),
      .rsp_last(rsp_last), .failures(failures), .pending(pending)
   );

   always @(negedge clock) begin
      rsp_ready <= quiet || ($urandom_range(99) >= 11);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic logic signed [31:0] pick_key();
      case ($urandom_range(7))
         0, 1, 2: return 32'(int'($urandom_range(10)) - 5);
         3:       return 32'sh8000_0000;
         4:       return 32'sh7fff_ffff;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [63:0] pick_tag();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // entered and left at a falling edge
   task automatic send_request(input sil_op_type op, input logic signed [31:0] key,
                               input logic [63:0] tag);
      while (!quiet && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_key       <= key;
      req_name_tag  <= tag;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (pending != 0)
         @(negedge clock);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_request(OP_DUMP, 32'sh7fff_ffff, '1);
      send_request(OP_INSERT, 32'sd0, '0);
      send_request(OP_INSERT, 32'sd0, '1);
      send_request(OP_INSERT, 32'sd0, pick_tag());
      send_request(OP_INSERT, 32'sh8000_0000, pick_tag());
      send_request(OP_INSERT, 32'sh8000_0000, pick_tag());
      send_request(OP_INSERT, 32'sh7fff_ffff, pick_tag());
      send_request(OP_INSERT, -32'sd1, '1);
      send_request(OP_DUMP, 32'sd0, '0);
      for (int i = 0; i < DEPTH - 7; i++)
         send_request(OP_INSERT, pick_key(), pick_tag());
      send_request(OP_INSERT, 32'sd5, '1);
      send_request(OP_DUMP, pick_key(), pick_tag());

      req_valid <= 1'b0;
      wait_drained();
      @(negedge clock);

      for (int i = 0; i < 130; i++) begin
         quiet = (i >= 40 && i < 80);
         send_request(($urandom_range(3) == 0) ? OP_DUMP : OP_INSERT,
                      pick_key(), pick_tag());
      end
      quiet = 1'b0;
      req_valid <= 1'b0;

      wait_drained();
      repeat (8) @(negedge clock);
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

>>> sorted_insert_list.f
rtl/core/sil_pkg.sv
rtl/core/sil_queue.sv
rtl/core/sil_table.sv
rtl/core/sorted_insert_list.sv
tb/sil_checker.sv
tb/tb.sv
